### sv/b64e_pkg.sv
// Shared types, constants and the sextet-to-ASCII map for the base64 stream encoder.
// No dependencies; the front, queue, back and top-level files import this package.
`default_nettype none

package b64e_pkg;

	// depth of the job queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	// characters a single input byte can produce at most
	localparam int unsigned MAX_CHARS = 4;

	localparam logic [6:0] CHAR_UPPER_A = 7'd65;
	localparam logic [6:0] LOWER_OFFSET = 7'd71;   // 'a' minus 26
	localparam logic [6:0] DIGIT_OFFSET = 7'd4;    // 52 minus '0'
	localparam logic [6:0] CHAR_PLUS    = 7'd43;
	localparam logic [6:0] CHAR_SLASH   = 7'd47;
	localparam logic [6:0] CHAR_PAD     = 7'd61;

	// position of the next byte inside its three-byte group
	typedef enum logic [1:0] {
		PH_0,
		PH_1,
		PH_2
	} phase_t;

	// one classified byte: the characters it produces, in order
	typedef struct packed {
		logic [MAX_CHARS-1:0][6:0] chars;
		logic [1:0]                n_m1;   // character count minus one
		logic                      last;   // final char of the job ends the message
	} job_t;

	// 6-bit code to base64 alphabet character
	function automatic logic [6:0] sextet_char(input logic [5:0] v);
		logic [6:0] w;
		w = {1'b0, v};
		if (v < 6'd26) begin
			return w + CHAR_UPPER_A;
		end else if (v < 6'd52) begin
			return w + LOWER_OFFSET;
		end else if (v < 6'd62) begin
			return w - DIGIT_OFFSET;
		end else if (v == 6'd62) begin
			return CHAR_PLUS;
		end else begin
			return CHAR_SLASH;
		end
	endfunction

endpackage

`default_nettype wire

### sv/b64e_in_if.sv
// Input byte channel of the base64 stream encoder: valid/ready plus byte and end flag.
// Standalone interface; no package dependency.
`default_nettype none

interface b64e_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       msg_end;

	modport source (output valid, output data_byte, output msg_end, input ready);
	modport sink   (input valid, input data_byte, input msg_end, output ready);
endinterface

`default_nettype wire

### sv/b64e_out_if.sv
// Output character channel of the base64 stream encoder: valid/ready plus ASCII code.
// Standalone interface; no package dependency.
`default_nettype none

interface b64e_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] out_char;
	logic       out_last;

	modport source (output valid, output out_char, output out_last, input ready);
	modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

`default_nettype wire

### sv/b64e_front.sv
// Front end: accepts bytes, tracks group phase and carry bits, builds one job per byte.
// Depends on b64e_pkg and b64e_in_if.
`default_nettype none

module b64e_front (
	input  logic          clk,
	input  logic          arst_n,
	b64e_in_if.sink       bytes,
	input  logic          q_full,
	output logic          push_valid,
	output b64e_pkg::job_t push_job
);
	import b64e_pkg::*;

	phase_t     phase_q, phase_nxt;
	logic [3:0] carry_q, carry_nxt;
	logic       take;
	logic [7:0] b;

	assign bytes.ready = !q_full;
	assign take        = bytes.valid && !q_full;
	assign push_valid  = take;
	assign b           = bytes.data_byte;

	// classify the byte by its place in the group
	always_comb begin
		push_job.chars = {MAX_CHARS{CHAR_PAD}};
		push_job.n_m1  = 2'd0;
		push_job.last  = bytes.msg_end;
		phase_nxt      = phase_q;
		carry_nxt      = carry_q;
		unique case (phase_q)
			PH_1: begin
				push_job.chars[0] = sextet_char({carry_q[1:0], b[7:4]});
				carry_nxt = b[3:0];
				phase_nxt = PH_2;
				if (bytes.msg_end) begin
					push_job.chars[1] = sextet_char({b[3:0], 2'b00});
					push_job.n_m1     = 2'd2;
				end
			end
			PH_2: begin
				push_job.chars[0] = sextet_char({carry_q, b[7:6]});
				push_job.chars[1] = sextet_char(b[5:0]);
				push_job.n_m1     = 2'd1;
				carry_nxt = 4'd0;
				phase_nxt = PH_0;
			end
			default: begin
				// start of group; the unused code behaves the same
				push_job.chars[0] = sextet_char(b[7:2]);
				carry_nxt = {2'b00, b[1:0]};
				phase_nxt = PH_1;
				if (bytes.msg_end) begin
					push_job.chars[1] = sextet_char({b[1:0], 4'b0000});
					push_job.n_m1     = 2'd3;
				end
			end
		endcase
		// message end returns to a fresh group
		if (bytes.msg_end) begin
			phase_nxt = PH_0;
			carry_nxt = 4'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_0;
			carry_q <= 4'd0;
		end else if (take) begin
			phase_q <= phase_nxt;
			carry_q <= carry_nxt;
		end
	end

	// a message end leaves a clean group behind
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(take && bytes.msg_end) |=> (phase_q == PH_0 && carry_q == 4'd0))
		else $error("group state not cleared after message end");

	// the carry never holds more than two bits at the start of a pair
	a_carry_phase1: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_1) |-> (carry_q[3:2] == 2'b00))
		else $error("carry too wide in phase one");

	// a byte inside a message yields one or two characters
	a_mid_msg_count: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !bytes.msg_end) |-> (push_job.n_m1 <= 2'd1))
		else $error("too many characters for a byte inside a message");

endmodule

`default_nettype wire

### sv/b64e_queue.sv
// Short job queue between the front and back of the base64 stream encoder.
// Depends on b64e_pkg for the job type.
`default_nettype none

module b64e_queue #(
	parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  b64e_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output b64e_pkg::job_t head_job,
	output logic           empty
);
	import b64e_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign push     = push_valid && !full;
	assign head_job = mem_q[rd_ptr_q];

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push_valid && full))
		else $error("push into full job queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty job queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("job queue count out of range");

endmodule

`default_nettype wire

### sv/b64e_back.sv
// Back end: takes jobs from the queue and sends their characters one per cycle while the receiver is ready.
// Depends on b64e_pkg and b64e_out_if.
`default_nettype none

module b64e_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  b64e_pkg::job_t head_job,
	output logic           pop,
	b64e_out_if.source     chars
);
	import b64e_pkg::*;

	job_t       job_q;
	logic       busy_q;
	logic [1:0] idx_q;
	logic       ov_q;
	logic [6:0] oc_q;
	logic       ol_q;
	logic       out_free;
	logic       emit;
	logic       at_end;
	logic       fin;

	assign out_free = !ov_q || chars.ready;
	assign emit     = busy_q && out_free;
	assign at_end   = (idx_q == job_q.n_m1);
	assign fin      = emit && at_end;
	assign pop      = !empty && (!busy_q || fin);

	assign chars.valid    = ov_q;
	assign chars.out_char = oc_q;
	assign chars.out_last = ol_q;

	// job sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= 2'd0;
		end else if (fin) begin
			busy_q <= 1'b0;
		end else if (emit) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit) begin
			ov_q <= 1'b1;
		end else if (chars.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			oc_q <= job_q.chars[idx_q];
			ol_q <= job_q.last && at_end;
		end
	end

	a_idx_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q <= job_q.n_m1))
		else $error("character index past end of job");

	a_last_from_job_end: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (ol_q == ($past(job_q.last) && $past(at_end))))
		else $error("end flag on wrong character");

	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !fin) |-> !pop)
		else $error("job taken while previous one still running");

endmodule

`default_nettype wire

### sv/base64_stream_encoder.sv
// Base64 stream encoder, top level: front end, job queue and back end.
// Depends on b64e_pkg, b64e_in_if, b64e_out_if, b64e_front, b64e_queue, b64e_back.
//
// Usage:
//   bytes : input channel, one message byte per request (data_byte, MSB first),
//           msg_end high on the final byte of a message. Every byte value is valid.
//   chars : output channel, one ASCII character per request (out_char), with
//           out_last high on the final character of the encoded message, '=' pads
//           included.
//   A byte yields one or two characters mid-group and up to four on a message end.
//   The front end classifies each byte in the cycle it is accepted and queues a job;
//   the back end sends one character per cycle from the queued jobs while the receiver is ready.
//   A byte's first character passes the queue, the job register and the output register.
//   The output register sends one character per cycle while the receiver is ready, so a long
//   message moves at four characters per three bytes; a byte ending a message at a group
//   start yields four characters.
//   When the receiver stalls, the output register holds its character and the
//   queue fills; bytes.ready drops once QDEPTH jobs are waiting.
//   Reset (arst_n low) empties the queue and output and starts a fresh group.
`default_nettype none

module base64_stream_encoder #(
	parameter int unsigned QDEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	b64e_in_if.sink    bytes,
	b64e_out_if.source chars
);
	import b64e_pkg::*;

	job_t push_job;
	job_t head_job;
	logic push_valid;
	logic q_full;
	logic q_empty;
	logic q_pop;

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.bytes      (bytes),
		.q_full     (q_full),
		.push_valid (push_valid),
		.push_job   (push_job)
	);

	b64e_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (q_pop),
		.head_job   (head_job),
		.empty      (q_empty)
	);

	b64e_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (q_empty),
		.head_job (head_job),
		.pop      (q_pop),
		.chars    (chars)
	);

endmodule

`default_nettype wire
